// ===== rtl/core/bm25_pkg.sv =====
// ----------------------------------------------------------------------------
// bm25_pkg
// Shared types and constants of the BM25 term score pipeline: status codes,
// register indexes, field widths and the side-band word carried by each stage.
// ----------------------------------------------------------------------------
`default_nettype none

package bm25_pkg;

  // Status codes of a result word.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SKIP  = 2'd1;
  localparam logic [1:0] STATUS_ERROR = 2'd2;

  // Configuration register indexes.
  localparam logic REG_DOCUMENT_COUNT   = 1'b0;
  localparam logic REG_TOTAL_TERM_COUNT = 1'b1;

  // Field and datapath widths.
  localparam int N_W     = 32;  // document count
  localparam int T_W     = 36;  // total term count
  localparam int F_W     = 20;  // term frequency and document length
  localparam int RATIO_W = 34;  // numerator and denominator of the ratio
  localparam int E_W     = 6;   // binary exponent of the ratio
  localparam int Y_W     = 32;  // series argument and powers
  localparam int SUM_W   = 33;  // series sum
  localparam int FRAC_W  = 34;  // doubled, clamped series sum
  localparam int IDF_W   = 38;  // inverse document frequency in Q32
  localparam int IDF44_W = 44;
  localparam int TFT_W   = 56;  // term frequency times total term count
  localparam int LN_W    = 52;  // document length times document count
  localparam int NUM_W   = 100; // score numerator
  localparam int DEN_W   = 61;  // score denominator
  localparam int SCORE_W = 40;

  // ln(2) in Q32 and the clamp for the doubled series sum (2.0 in Q32).
  localparam logic [31:0]       LN2_Q32  = 32'd2977044471;
  localparam logic [FRAC_W-1:0] FRAC_MAX = 34'h2_0000_0000;

  // Side-band word that travels with every item.
  typedef struct packed {
    logic [1:0]     status;
    logic [F_W-1:0] tf;
    logic [F_W-1:0] len;
    logic [E_W-1:0] e;
  } side_t;

endpackage

`default_nettype wire

// ===== rtl/core/bm25_term_score.sv =====
// ----------------------------------------------------------------------------
// bm25_term_score
// Fixed-point Okapi BM25 contribution of one posting (k1 1.2, b 0.75) as a
// fully pipelined datapath: ratio normaliser, restoring divider, atanh series,
// wide product and a second restoring divider for the score.
// ----------------------------------------------------------------------------
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  config    | cfg_we, cfg_index, cfg_data               | in
//  posting   | posting_valid, posting_stall,             | in
//            | doc_freq, term_freq, doc_length           |
//  result    | result_valid, result_stall, score, status | out
//
// One posting word enters per cycle while the result is not stalled. The pipe
// runs through the normaliser, the 32-step ratio divider, three stages per
// series term, the score operand stages and the 40-step score divider.
// Reset clears all valid bits and sets both registers to 1.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
// Registers are sampled live and must only be written while the pipe is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module bm25_term_score #(
  parameter int LAST_ODD_DIVISOR = 15
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [35:0] cfg_data,
  input  wire logic        posting_valid,
  output logic             posting_stall,
  input  wire logic [31:0] doc_freq,
  input  wire logic [19:0] term_freq,
  input  wire logic [19:0] doc_length,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [39:0]      score,
  output logic [1:0]       status
);

  localparam int NTERMS = (LAST_ODD_DIVISOR - 1) / 2;
  localparam int EW     = bm25_pkg::E_W;
  localparam int QY     = bm25_pkg::Y_W;
  localparam int QS     = bm25_pkg::SCORE_W;

  // Configuration registers.
  logic [bm25_pkg::N_W-1:0] n;
  logic [bm25_pkg::T_W-1:0] t;

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= 32'd1;
      t <= 36'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bm25_pkg::REG_DOCUMENT_COUNT:   n <= cfg_data[31:0];
        bm25_pkg::REG_TOTAL_TERM_COUNT: t <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipe advances unless a finished word is held at the output.
  logic adv;
  assign adv           = !result_valid || !result_stall;
  assign posting_stall = !adv;

  // Entry stage and ratio normaliser: stage 0 holds the entry registers.
  logic                         nm_v    [0:EW];
  bm25_pkg::side_t              nm_side [0:EW];
  logic [bm25_pkg::RATIO_W-1:0] nm_num  [0:EW];
  logic [bm25_pkg::RATIO_W-1:0] nm_den  [0:EW];

  always_ff @(posedge clk) begin
    if (rst) begin
      nm_v[0] <= 1'b0;
    end else if (adv) begin
      nm_v[0] <= posting_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nm_num[0] <= {1'b0, n, 1'b0} + 34'd2;
      nm_den[0] <= {1'b0, doc_freq, 1'b1};
      if (doc_freq == 32'd0) begin
        nm_side[0].status <= bm25_pkg::STATUS_SKIP;
      end else if (doc_freq > n) begin
        nm_side[0].status <= bm25_pkg::STATUS_ERROR;
      end else begin
        nm_side[0].status <= bm25_pkg::STATUS_OK;
      end
      nm_side[0].tf  <= term_freq;
      nm_side[0].len <= doc_length;
      nm_side[0].e   <= '0;
    end
  end

  // Each stage settles one exponent bit, most significant first: the bit is
  // kept when the shifted denominator still does not exceed the numerator.
  for (genvar j = 1; j <= EW; j++) begin : g_norm
    localparam int B = EW - j;
    localparam logic [EW-1:0] BIT_MASK = EW'(1 << B);
    logic [EW-1:0]   cand;
    logic            fits;
    bm25_pkg::side_t side_next;

    assign cand = nm_side[j-1].e | BIT_MASK;
    assign fits = nm_den[j-1] <= (nm_num[j-1] >> cand);

    always_comb begin
      side_next = nm_side[j-1];
      if (fits) begin
        side_next.e = cand;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        nm_v[j] <= 1'b0;
      end else if (adv) begin
        nm_v[j] <= nm_v[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        nm_num[j]  <= nm_num[j-1];
        nm_den[j]  <= nm_den[j-1];
        nm_side[j] <= side_next;
      end
    end
  end

  // Divider setup: y = floor((num - dn) * 2^32 / (num + dn)).
  logic [bm25_pkg::RATIO_W-1:0] dn;
  assign dn = nm_den[EW] << nm_side[EW].e;

  logic            dv_v    [0:QY];
  bm25_pkg::side_t dv_side [0:QY];
  logic [34:0]     dv_r    [0:QY];
  logic [34:0]     dv_s    [0:QY];
  logic [QY-1:0]   dv_q    [0:QY];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= nm_v[EW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_side[0] <= nm_side[EW];
      dv_r[0]    <= 35'(nm_num[EW] - dn);
      dv_s[0]    <= {1'b0, nm_num[EW]} + {1'b0, dn};
      dv_q[0]    <= '0;
    end
  end

  // Restoring divider, one quotient bit per stage.
  for (genvar j = 1; j <= QY; j++) begin : g_ydiv
    logic [35:0] r2;
    logic        ge;

    assign r2 = {dv_r[j-1], 1'b0};
    assign ge = r2 >= {1'b0, dv_s[j-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j] <= 1'b0;
      end else if (adv) begin
        dv_v[j] <= dv_v[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_side[j] <= dv_side[j-1];
        dv_s[j]    <= dv_s[j-1];
        dv_r[j]    <= ge ? 35'(r2 - {1'b0, dv_s[j-1]}) : r2[34:0];
        dv_q[j]    <= {dv_q[j-1][QY-2:0], ge};
      end
    end
  end

  // Series state: index 0 holds y, y squared and the first term of the sum.
  logic                       tp_v    [0:NTERMS];
  bm25_pkg::side_t            tp_side [0:NTERMS];
  logic [QY-1:0]              tp_y2   [0:NTERMS];
  logic [QY-1:0]              tp_p    [0:NTERMS];
  logic [bm25_pkg::SUM_W-1:0] tp_s    [0:NTERMS];

  logic [63:0] ysq;
  assign ysq = 64'(dv_q[QY]) * 64'(dv_q[QY]);

  always_ff @(posedge clk) begin
    if (rst) begin
      tp_v[0] <= 1'b0;
    end else if (adv) begin
      tp_v[0] <= dv_v[QY];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tp_side[0] <= dv_side[QY];
      tp_y2[0]   <= ysq[63:32];
      tp_p[0]    <= dv_q[QY];
      tp_s[0]    <= {1'b0, dv_q[QY]};
    end
  end

  // One series term per block: next odd power, divide by the odd constant
  // through a reciprocal, then correct the estimate by at most one.
  for (genvar j = 1; j <= NTERMS; j++) begin : g_term
    localparam int K = 2 * j + 1;
    localparam logic [34:0] RECIP = 35'((64'd1 << 36) / K);

    logic                       a_v, b_v;
    bm25_pkg::side_t            a_side, b_side;
    logic [QY-1:0]              a_y2, b_y2, a_p, b_p, b_qest;
    logic [bm25_pkg::SUM_W-1:0] a_s, b_s;
    logic [63:0]                pwr;
    logic [66:0]                qprod;
    logic [36:0]                qk;
    logic [QY-1:0]              rem;
    logic                       adj;

    assign pwr   = 64'(tp_p[j-1]) * 64'(tp_y2[j-1]);
    assign qprod = 67'(a_p) * 67'(RECIP);
    assign qk    = 37'(b_qest) * 37'(K);
    assign rem   = 32'(37'(b_p) - qk);
    assign adj   = rem >= 32'(K);

    always_ff @(posedge clk) begin
      if (rst) begin
        a_v     <= 1'b0;
        b_v     <= 1'b0;
        tp_v[j] <= 1'b0;
      end else if (adv) begin
        a_v     <= tp_v[j-1];
        b_v     <= a_v;
        tp_v[j] <= b_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        a_side     <= tp_side[j-1];
        a_y2       <= tp_y2[j-1];
        a_p        <= pwr[63:32];
        a_s        <= tp_s[j-1];
        b_side     <= a_side;
        b_y2       <= a_y2;
        b_p        <= a_p;
        b_s        <= a_s;
        b_qest     <= 32'(qprod >> 36);
        tp_side[j] <= b_side;
        tp_y2[j]   <= b_y2;
        tp_p[j]    <= b_p;
        tp_s[j]    <= b_s + 33'(b_qest) + 33'(adj);
      end
    end
  end

  // Inverse document frequency: clamp the doubled sum, add e * ln2.
  logic [bm25_pkg::FRAC_W-1:0] frac2;
  assign frac2 = {tp_s[NTERMS], 1'b0};

  logic                        f_v, g_v;
  bm25_pkg::side_t             f_side, g_side;
  logic [bm25_pkg::FRAC_W-1:0] f_frac;
  logic [bm25_pkg::IDF_W-1:0]  f_elog, g_idf;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
      g_v <= 1'b0;
    end else if (adv) begin
      f_v <= tp_v[NTERMS];
      g_v <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_side <= tp_side[NTERMS];
      f_frac <= (frac2 > bm25_pkg::FRAC_MAX) ? bm25_pkg::FRAC_MAX : frac2;
      f_elog <= 38'(tp_side[NTERMS].e) * 38'(bm25_pkg::LN2_Q32);
      g_side <= f_side;
      g_idf  <= f_elog + 38'(f_frac);
    end
  end

  // Score operands: products of two variables split into pieces of at most 32 bits.
  logic                         s1_v, s2_v, s3_v, s4_v;
  logic [1:0]                   s1_st, s2_st, s3_st, s4_st;
  logic [bm25_pkg::IDF44_W-1:0] s1_idf44, s2_idf44;
  logic [51:0]                  s1_pa;
  logic [23:0]                  s1_pb;
  logic [bm25_pkg::LN_W-1:0]    s1_ln, s2_ln;
  logic [bm25_pkg::TFT_W-1:0]   s2_tft;
  logic [49:0]                  s3_p00, s3_p01, s3_p10, s3_p11;
  logic [bm25_pkg::DEN_W-1:0]   s3_da, s3_db, s4_den;
  logic [77:0]                  s4_m0, s4_m1;
  logic [bm25_pkg::NUM_W-1:0]   numer;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else if (adv) begin
      s1_v <= g_v;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_st    <= g_side.status;
      s1_idf44 <= 44'(g_idf) * 44'(44);
      s1_pa    <= 52'(g_side.tf) * 52'(t[31:0]);
      s1_pb    <= 24'(g_side.tf) * 24'(t[35:32]);
      s1_ln    <= 52'(g_side.len) * 52'(n);

      s2_st    <= s1_st;
      s2_idf44 <= s1_idf44;
      s2_ln    <= s1_ln;
      s2_tft   <= 56'(s1_pa) + (56'(s1_pb) << 32);

      s3_st    <= s2_st;
      s3_p00   <= 50'(s2_idf44[21:0]) * 50'(s2_tft[27:0]);
      s3_p01   <= 50'(s2_idf44[21:0]) * 50'(s2_tft[55:28]);
      s3_p10   <= 50'(s2_idf44[43:22]) * 50'(s2_tft[27:0]);
      s3_p11   <= 50'(s2_idf44[43:22]) * 50'(s2_tft[55:28]);
      s3_da    <= 61'(s2_tft) * 61'(20);
      s3_db    <= 61'(t) * 61'(6) + 61'(s2_ln) * 61'(18);

      s4_st    <= s3_st;
      s4_m0    <= 78'(s3_p00) + (78'(s3_p01) << 28);
      s4_m1    <= 78'(s3_p10) + (78'(s3_p11) << 28);
      s4_den   <= s3_da + s3_db;
    end
  end

  assign numer = 100'(s4_m0) + (100'(s4_m1) << 22);

  // Score divider: the quotient fits 40 bits, so the upper numerator bits
  // already lie below the divisor and only 40 steps remain.
  logic                       qd_v   [0:QS];
  logic [1:0]                 qd_st  [0:QS];
  logic                       qd_dz  [0:QS];
  logic [bm25_pkg::DEN_W-1:0] qd_den [0:QS];
  logic [bm25_pkg::DEN_W-1:0] qd_r   [0:QS];
  logic [QS-1:0]              qd_n   [0:QS];
  logic [QS-1:0]              qd_q   [0:QS];

  always_ff @(posedge clk) begin
    if (rst) begin
      qd_v[0] <= 1'b0;
    end else if (adv) begin
      qd_v[0] <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qd_st[0]  <= s4_st;
      qd_dz[0]  <= s4_den == '0;
      qd_den[0] <= s4_den;
      qd_r[0]   <= {1'b0, numer[99:40]};
      qd_n[0]   <= numer[39:0];
      qd_q[0]   <= '0;
    end
  end

  for (genvar j = 1; j <= QS; j++) begin : g_sdiv
    logic [bm25_pkg::DEN_W:0] r2;
    logic                     ge;

    assign r2 = {qd_r[j-1], qd_n[j-1][QS-1]};
    assign ge = r2 >= {1'b0, qd_den[j-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        qd_v[j] <= 1'b0;
      end else if (adv) begin
        qd_v[j] <= qd_v[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        qd_st[j]  <= qd_st[j-1];
        qd_dz[j]  <= qd_dz[j-1];
        qd_den[j] <= qd_den[j-1];
        qd_r[j]   <= ge ? 61'(r2 - {1'b0, qd_den[j-1]}) : r2[60:0];
        qd_n[j]   <= {qd_n[j-1][QS-2:0], 1'b0};
        qd_q[j]   <= {qd_q[j-1][QS-2:0], ge};
      end
    end
  end

  // Output register: flagged words and a zero divisor give a zero score.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= qd_v[QS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status <= qd_st[QS];
      if (qd_st[QS] == bm25_pkg::STATUS_OK && !qd_dz[QS]) begin
        score <= qd_q[QS];
      end else begin
        score <= '0;
      end
    end
  end

  // Checks on the datapath.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid straight after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status == bm25_pkg::STATUS_OK ||
                      status == bm25_pkg::STATUS_SKIP ||
                      status == bm25_pkg::STATUS_ERROR))
    else $error("undefined status code on result");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != bm25_pkg::STATUS_OK |-> score == '0)
    else $error("flagged result carries a nonzero score");

  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    nm_v[EW] && nm_side[EW].status == bm25_pkg::STATUS_OK |->
      dn <= nm_num[EW] && {1'b0, nm_num[EW]} < {dn, 1'b0})
    else $error("normaliser left the ratio outside one to two");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    qd_v[QS] && !qd_dz[QS] |-> qd_r[QS] < qd_den[QS])
    else $error("score divider remainder not below divisor");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// BM25 term score testbench
// Drives posting words through bm25_term_score under several register
// settings and idle patterns. Every result word is checked against a local
// fixed-point model of the score and its status.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LAST_ODD_DIV = 15;
  localparam int DRAIN_CYCLES = 150;
  localparam int STALL_LIMIT  = 5000;

  typedef struct packed {
    logic [bm25_pkg::SCORE_W-1:0] score;
    logic [1:0]                   status;
  } score_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = bm25_pkg::REG_DOCUMENT_COUNT;
  logic [35:0] cfg_data = '0;
  logic        posting_valid = 1'b0;
  logic        posting_stall;
  logic [31:0] doc_freq = '0;
  logic [19:0] term_freq = '0;
  logic [19:0] doc_length = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [39:0] score;
  logic [1:0]  status;

  // Local copy of the two registers.
  logic [63:0] doc_count  = 64'd1;
  logic [63:0] term_total = 64'd1;

  score_word_t expected_scores[$];
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          mismatches = 0;
  int          words_sent = 0;
  int          words_checked = 0;
  int          quiet_cycles = 0;

  bm25_term_score DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .posting_valid(posting_valid),
    .posting_stall(posting_stall), .doc_freq(doc_freq),
    .term_freq(term_freq), .doc_length(doc_length),
    .result_valid(result_valid), .result_stall(result_stall),
    .score(score), .status(status)
  );

  always #5 clk = ~clk;

  // Fixed-point score: ln((2N+2)/(2df+1)) by normalisation and atanh series.
  function automatic score_word_t bm25_score(input logic [31:0] df,
                                             input logic [19:0] tf,
                                             input logic [19:0] len);
    score_word_t w;
    logic [63:0]  num, den, expo, y, y2, pw, sum, frac, idf;
    logic [127:0] shifted, sden, prod;
    w.score  = '0;
    w.status = bm25_pkg::STATUS_OK;
    if (df == 0) begin
      w.status = bm25_pkg::STATUS_SKIP;
      return w;
    end
    if (64'(df) > doc_count) begin
      w.status = bm25_pkg::STATUS_ERROR;
      return w;
    end
    num  = doc_count * 2 + 2;
    den  = 64'(df) * 2 + 1;
    expo = 0;
    while (num >= den * 2) begin
      den  = den * 2;
      expo = expo + 1;
    end
    shifted = 128'(num - den) << 32;
    y   = 64'(shifted / 128'(num + den));
    y2  = (y * y) >> 32;
    pw  = y;
    sum = y;
    for (int k = 3; k <= LAST_ODD_DIV; k += 2) begin
      pw  = (pw * y2) >> 32;
      sum = sum + pw / k;
    end
    frac = sum * 2;
    if (frac > 64'h2_0000_0000) frac = 64'h2_0000_0000;
    idf  = expo * 64'(bm25_pkg::LN2_Q32) + frac;
    sden = 128'd20 * 128'(tf) * 128'(term_total) + 128'd6 * 128'(term_total)
         + 128'd18 * 128'(len) * 128'(doc_count);
    if (sden != 0) begin
      prod    = 128'(idf) * 128'd44 * 128'(tf) * 128'(term_total);
      w.score = bm25_pkg::SCORE_W'(prod / sden);
    end
    return w;
  endfunction

  // Result checker and receiver stall.
  always @(posedge clk) begin
    score_word_t exp_w;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        words_checked++;
        if (expected_scores.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result word: score %0d status %0d",
                                         score, status);
        end else begin
          exp_w = expected_scores.pop_front();
          if (score !== exp_w.score || status !== exp_w.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected score %0d status %0d, got score %0d status %0d",
                       exp_w.score, exp_w.status, score, status);
          end
        end
      end
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: cycles with no word accepted on either side.
  always @(posedge clk) begin
    if ((posting_valid && !posting_stall) || (result_valid && !result_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout with %0d results outstanding", expected_scores.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Sends one posting word and records its expected result on acceptance.
  task automatic send_posting(input logic [31:0] df, input logic [19:0] tf,
                              input logic [19:0] len);
    score_word_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      posting_valid <= 1'b0;
      @(posedge clk);
    end
    w = bm25_score(df, tf, len);
    posting_valid <= 1'b1;
    doc_freq      <= df;
    term_freq     <= tf;
    doc_length    <= len;
    do @(posedge clk); while (posting_stall);
    expected_scores.insert(expected_scores.size(), w);
    words_sent++;
  endtask

  task automatic end_of_burst();
    posting_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits for the pipe to empty, then writes both registers.
  task automatic write_registers(input logic [31:0] n, input logic [35:0] t);
    end_of_burst();
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= bm25_pkg::REG_DOCUMENT_COUNT;
    cfg_data  <= 36'(n);
    @(posedge clk);
    cfg_index <= bm25_pkg::REG_TOTAL_TERM_COUNT;
    cfg_data  <= t;
    @(posedge clk);
    cfg_we     <= 1'b0;
    doc_count  = 64'(n);
    term_total = 64'(t);
  endtask

  // A random posting: mostly in range, some skipped, some beyond N.
  task automatic send_random_posting();
    logic [31:0] df;
    logic [19:0] tf, len;
    int pick;
    pick = $urandom_range(9);
    if (pick == 0)
      df = 0;
    else if (pick == 1 && doc_count < 64'hFFFF_FFFF)
      df = 32'(doc_count + 1 + ($urandom_range(1) ? 0 : $urandom_range(1000)));
    else if (pick == 2 || doc_count == 0)
      df = $urandom;
    else if (pick == 3)
      df = $urandom >> $urandom_range(31);
    else
      df = $urandom_range(32'(doc_count), 1);
    if (df > doc_count && pick > 2 && doc_count != 0) df = 32'(doc_count);
    tf  = $urandom_range(1) ? 20'($urandom_range(64, 1)) : 20'($urandom);
    len = $urandom_range(1) ? 20'($urandom_range(2000, 1)) : 20'($urandom);
    send_posting(df, tf, len);
  endtask

  task automatic test_directed();
    // Reset values first, then a mid-size index.
    send_posting(32'd1, 20'd1, 20'd1);
    send_posting(32'd0, 20'd3, 20'd7);
    send_posting(32'd2, 20'd1, 20'd1);
    write_registers(32'd1000, 36'd50000);
    send_posting(32'd1, 20'd1, 20'd1);
    send_posting(32'd1000, 20'd5, 20'd50);
    send_posting(32'd1001, 20'd5, 20'd50);
    send_posting(32'hFFFF_FFFF, 20'd5, 20'd50);
    send_posting(32'd0, 20'hFFFFF, 20'hFFFFF);
    send_posting(32'd10, 20'hFFFFF, 20'd1);
    send_posting(32'd10, 20'd1, 20'hFFFFF);
    send_posting(32'd10, 20'd0, 20'd10);
    send_posting(32'd10, 20'd10, 20'd0);
    send_posting(32'd500, 20'hFFFFF, 20'hFFFFF);
    // Zero total term count with zero document length gives a zero divisor.
    write_registers(32'hFFFF_FFFF, 36'd0);
    send_posting(32'd1, 20'd5, 20'd0);
    send_posting(32'd1, 20'd5, 20'd9);
    send_posting(32'hFFFF_FFFF, 20'hFFFFF, 20'hFFFFF);
    // Zero document count: every nonzero frequency is an error.
    write_registers(32'd0, 36'hF_FFFF_FFFF);
    send_posting(32'd1, 20'd1, 20'd1);
    send_posting(32'd0, 20'd1, 20'd1);
    write_registers(32'hFFFF_FFFF, 36'hF_FFFF_FFFF);
    send_posting(32'd1, 20'hFFFFF, 20'd1);
    send_posting(32'hFFFF_FFFF, 20'd1, 20'hFFFFF);
    send_posting(32'h5555_5555, 20'hAAAAA, 20'h55555);
    end_of_burst();
  endtask

  task automatic test_register_extremes();
    logic [31:0] n_set[5] = '{32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd0};
    logic [35:0] t_set[5] = '{36'd1, 36'hF_FFFF_FFFF, 36'd1, 36'hF_FFFF_FFFF, 36'd0};
    for (int i = 0; i < 5; i++) begin
      write_registers(n_set[i], t_set[i]);
      repeat (50) send_random_posting();
    end
    end_of_burst();
  endtask

  task automatic test_idle_phases();
    int idle_set[4]  = '{0, 52, 0, 35};
    int stall_set[4] = '{0, 0, 52, 35};
    logic [63:0] t_raw;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_set[ph];
      stall_pct     = stall_set[ph];
      for (int c = 0; c < 2; c++) begin
        t_raw = {$urandom, $urandom} >> $urandom_range(63, 28);
        write_registers(($urandom >> $urandom_range(31)) | 32'd1,
                        36'(t_raw) | 36'd1);
        repeat (120) send_random_posting();
      end
    end
    send_idle_pct = 0;
    stall_pct     = 0;
    end_of_burst();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_idle_phases();
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d posting words and checked %0d scores over directed, extreme",
             words_sent, words_checked);
    $display("and random register settings with sender gaps and receiver stalls; %0d mismatches.",
             mismatches);
    if (mismatches == 0 && expected_scores.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
